// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker module.
// Depends on nothing; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk, masked while rst is high.
`define HCBD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define HCBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/hcbd_pkg.sv -----
// Types and constants for the handheld console bus decoder.
// No dependencies; used by every module of the block but hcbd_ram.
package hcbd_pkg;

   // Target codes
   localparam logic [3:0] TGT_NONE   = 4'd0;
   localparam logic [3:0] TGT_BOOT   = 4'd1;
   localparam logic [3:0] TGT_CROM   = 4'd2;
   localparam logic [3:0] TGT_VRAM   = 4'd3;
   localparam logic [3:0] TGT_CRAM   = 4'd4;
   localparam logic [3:0] TGT_OAM    = 4'd5;
   localparam logic [3:0] TGT_PAD    = 4'd6;
   localparam logic [3:0] TGT_TIMER  = 4'd7;
   localparam logic [3:0] TGT_IF     = 4'd8;
   localparam logic [3:0] TGT_APU    = 4'd9;
   localparam logic [3:0] TGT_WAVE   = 4'd10;
   localparam logic [3:0] TGT_PPU    = 4'd11;
   localparam logic [3:0] TGT_DMA    = 4'd12;
   localparam logic [3:0] TGT_IE     = 4'd13;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // I/O register offsets (low address byte in page FF)
   localparam logic [7:0] IO_PAD    = 8'h00;
   localparam logic [7:0] IO_IF     = 8'h0F;
   localparam logic [7:0] IO_LY     = 8'h44;
   localparam logic [7:0] IO_OAMDMA = 8'h46;
   localparam logic [7:0] IO_KEY0   = 8'h4C;
   localparam logic [7:0] IO_KEY1   = 8'h4D;
   localparam logic [7:0] IO_VBK    = 8'h4F;
   localparam logic [7:0] IO_BOOT   = 8'h50;
   localparam logic [7:0] IO_HDMA5  = 8'h55;
   localparam logic [7:0] IO_OPRI   = 8'h6C;
   localparam logic [7:0] IO_SVBK   = 8'h70;
   localparam logic [7:0] WAVE_BASE = 8'h30;

   localparam logic [7:0] OPEN_BUS  = 8'hFF;
   localparam logic [2:0] BANK_DFLT = 3'd1;

   localparam int WRAM_BANK_BYTES = 4096;
   localparam int BANK_OFS_W      = $clog2(WRAM_BANK_BYTES);
   localparam int HRAM_BYTES      = 127;
   localparam int HRAM_AW         = $clog2(HRAM_BYTES);

   typedef struct packed {
      logic        operation;
      logic [15:0] address;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic [3:0]  target;
      logic [14:0] target_address;
      logic        target_write;
      logic [7:0]  forward_data;
      logic        read_valid;
      logic [7:0]  read_data;
   } rsp_type;

   // Where the read byte comes from
   typedef enum logic [1:0] {
      SRC_REG  = 2'd0,
      SRC_WRAM = 2'd1,
      SRC_HRAM = 2'd2
   } src_type;

   // Local state seen by the decoder
   typedef struct packed {
      logic       cart_present;
      logic       boot_on;
      logic [2:0] bank;
      logic [7:0] mode_key;
      logic [7:0] speed_key;
   } state_type;

   // Store and register write controls from the decoder
   typedef struct packed {
      logic    wram_en;
      logic    wram_we;
      logic    wram_banked;
      logic    hram_en;
      logic    hram_we;
      logic    bank_we;
      logic    boot_clr;
      logic    mode_we;
      logic    speed_we;
      src_type src;
   } ctl_type;

endpackage

// ----- hw/rtl/hcbd_ram.sv -----
// Single-port synchronous RAM with a registered read.
// No dependencies.
module hcbd_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/hcbd_decode.sv -----
// Address decoder: memory map, routing, local register reads and write controls.
// Depends on hcbd_pkg.
module hcbd_decode (
   input  hcbd_pkg::req_type   req,
   input  hcbd_pkg::state_type st,
   output hcbd_pkg::rsp_type   rsp,
   output hcbd_pkg::ctl_type   ctl
);

   logic        wr;
   logic [15:0] a;
   logic [7:0]  io;
   logic [7:0]  io_off;
   logic        local_acc;
   logic [3:0]  tgt;
   logic [14:0] toff;
   logic [7:0]  rd;

   always_comb begin
      wr        = (req.operation == hcbd_pkg::OP_WRITE);
      a         = req.address;
      io        = a[7:0];
      io_off    = 8'h00;
      local_acc = 1'b0;
      tgt       = hcbd_pkg::TGT_NONE;
      toff      = '0;
      rd        = hcbd_pkg::OPEN_BUS;
      ctl       = '0;
      ctl.src   = hcbd_pkg::SRC_REG;

      priority if (!a[15]) begin
         // ROM area; boot overlay leaves 0100-01FF to the cartridge
         if (st.boot_on && (a[15:8] != 8'h01)) begin
            if (!wr) begin
               tgt  = hcbd_pkg::TGT_BOOT;
               toff = a[14:0];
            end
         end else if (st.cart_present) begin
            tgt  = hcbd_pkg::TGT_CROM;
            toff = a[14:0];
         end else begin
            local_acc = 1'b1;
         end
      end else if (a[15:13] == 3'b100) begin
         tgt  = hcbd_pkg::TGT_VRAM;
         toff = {2'b00, a[12:0]};
      end else if (a[15:13] == 3'b101) begin
         if (st.cart_present) begin
            tgt  = hcbd_pkg::TGT_CRAM;
            toff = {2'b00, a[12:0]};
         end else begin
            local_acc = 1'b1;
         end
      end else if (a[15:8] <= 8'hFD) begin
         // C000-FDFF: pages C/E fixed bank, D/F switchable bank
         local_acc       = 1'b1;
         ctl.wram_en     = 1'b1;
         ctl.wram_we     = wr;
         ctl.wram_banked = a[12];
         ctl.src         = hcbd_pkg::SRC_WRAM;
      end else if (a[15:8] == 8'hFE) begin
         tgt  = hcbd_pkg::TGT_OAM;
         toff = {7'd0, io};
      end else if (a == 16'hFFFF) begin
         tgt  = hcbd_pkg::TGT_IE;
         toff = {7'd0, io};
      end else if (a[7]) begin
         local_acc   = 1'b1;
         ctl.hram_en = 1'b1;
         ctl.hram_we = wr;
         ctl.src     = hcbd_pkg::SRC_HRAM;
      end else begin
         local_acc = 1'b1;
         priority if (io == hcbd_pkg::IO_PAD) begin
            tgt = hcbd_pkg::TGT_PAD;
         end else if (io >= 8'h04 && io <= 8'h07) begin
            tgt = hcbd_pkg::TGT_TIMER;
         end else if (io == hcbd_pkg::IO_IF) begin
            tgt = hcbd_pkg::TGT_IF;
         end else if (io >= 8'h10 && io <= 8'h27) begin
            tgt = hcbd_pkg::TGT_APU;
         end else if (io >= 8'h30 && io <= 8'h3F) begin
            tgt = hcbd_pkg::TGT_WAVE;
         end else if ((io >= 8'h40 && io <= 8'h4B && io != hcbd_pkg::IO_LY &&
                       io != hcbd_pkg::IO_OAMDMA) || io == hcbd_pkg::IO_VBK ||
                      (io >= 8'h68 && io <= 8'h6B)) begin
            tgt = hcbd_pkg::TGT_PPU;
         end else if (io == hcbd_pkg::IO_LY) begin
            if (!wr) tgt = hcbd_pkg::TGT_PPU;
         end else if (io == hcbd_pkg::IO_OAMDMA) begin
            if (wr) tgt = hcbd_pkg::TGT_PPU;
         end else if (io == hcbd_pkg::IO_OPRI) begin
            if (!wr || st.boot_on) tgt = hcbd_pkg::TGT_PPU;
         end else if (io >= 8'h51 && io <= 8'h54) begin
            if (wr) tgt = hcbd_pkg::TGT_DMA;
         end else if (io == hcbd_pkg::IO_HDMA5) begin
            tgt = hcbd_pkg::TGT_DMA;
         end else if (io == hcbd_pkg::IO_KEY0) begin
            ctl.mode_we = wr && st.boot_on;
            rd          = st.mode_key;
         end else if (io == hcbd_pkg::IO_KEY1) begin
            ctl.speed_we = wr;
            rd           = st.mode_key[2] ? hcbd_pkg::OPEN_BUS : st.speed_key;
         end else if (io == hcbd_pkg::IO_BOOT) begin
            ctl.boot_clr = wr;
            rd           = {7'd0, st.boot_on};
         end else if (io == hcbd_pkg::IO_SVBK) begin
            ctl.bank_we = wr;
            rd          = {5'd0, st.bank};
         end else begin
            rd = hcbd_pkg::OPEN_BUS;
         end
         if (tgt != hcbd_pkg::TGT_NONE) begin
            local_acc = 1'b0;
            io_off    = (tgt == hcbd_pkg::TGT_WAVE) ? (io - hcbd_pkg::WAVE_BASE) : io;
            toff      = {7'd0, io_off};
         end
      end

      rsp.target         = tgt;
      rsp.target_address = toff;
      rsp.target_write   = wr && (tgt != hcbd_pkg::TGT_NONE);
      rsp.forward_data   = rsp.target_write ? req.write_data : 8'h00;
      rsp.read_valid     = !wr && local_acc;
      rsp.read_data      = rsp.read_valid ? rd : 8'h00;
      if (!rsp.read_valid) begin
         ctl.src = hcbd_pkg::SRC_REG;
      end
   end

endmodule

// ----- hw/rtl/handheld_console_bus_decoder_top.sv -----
// Handheld console bus decoder, top level.
// Depends on hcbd_pkg, hcbd_decode and hcbd_ram.
//
// Decodes one CPU bus access per item against the console memory map. Items
// for external units come out as a target code, an offset and, on writes,
// the forwarded byte; work RAM, echo RAM, high RAM, the boot flag, the bank
// register and the two key registers are served here. Throughput is one item
// per clock while rsp_ready does not stall the output: all state (both RAMs
// and the local registers) is read and updated at the edge the item is
// accepted, so the next access always sees the previous write. The RAM read
// port registers its data, then the result lands in an output register,
// which lets a new item in while a result still waits on rsp_ready. After
// reset a clearing pass zeroes work RAM (and high RAM alongside) one entry a
// cycle, during which req_ready is low; csr writes are taken as ever.
module handheld_console_bus_decoder_top #(
   parameter int WRAM_BANKS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hcbd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hcbd_pkg::rsp_type rsp_payload,
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);

   localparam int WRAM_DEPTH = WRAM_BANKS * hcbd_pkg::WRAM_BANK_BYTES;
   localparam int BANK_W     = $clog2(WRAM_BANKS);
   localparam int WRAM_AW    = $clog2(WRAM_DEPTH);
   localparam logic [3:0] BANKS_N = 4'(WRAM_BANKS);

   // Local registers
   logic       cart_ff, cart_in;
   logic       boot_ff, boot_in;
   logic [2:0] bank_ff, bank_in;
   logic [7:0] mode_ff, mode_in;
   logic [7:0] speed_ff, speed_in;

   // Clearing pass
   logic               clr_active_ff, clr_active_in;
   logic [WRAM_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic               hram_clr;

   // Pipeline: stage 1 waits on RAM read data, stage 2 is the output register
   logic              s1_valid_ff, s1_valid_in;
   hcbd_pkg::rsp_type s1_rsp_ff, s1_rsp_in;
   hcbd_pkg::src_type s1_src_ff, s1_src_in;
   logic              out_valid_ff, out_valid_in;
   hcbd_pkg::rsp_type out_rsp_ff, out_rsp_in;
   logic              s1_move;
   logic              accept;

   hcbd_pkg::state_type st;
   hcbd_pkg::rsp_type   dec_rsp;
   hcbd_pkg::ctl_type   dec_ctl;

   // RAM ports
   logic [3:0]                 bank_mod;
   logic [BANK_W-1:0]          wram_bank;
   logic                       wram_en, wram_we;
   logic [WRAM_AW-1:0]         wram_addr;
   logic [7:0]                 wram_wdata, wram_rdata;
   logic                       hram_en, hram_we;
   logic [hcbd_pkg::HRAM_AW-1:0] hram_addr;
   logic [7:0]                 hram_wdata, hram_rdata;

   assign st.cart_present = cart_ff;
   assign st.boot_on      = boot_ff;
   assign st.bank         = bank_ff;
   assign st.mode_key     = mode_ff;
   assign st.speed_key    = speed_ff;

   hcbd_decode u_decode (
      .req (req_payload),
      .st  (st),
      .rsp (dec_rsp),
      .ctl (dec_ctl)
   );

   // Handshake
   assign s1_move   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !clr_active_ff && (!s1_valid_ff || s1_move);
   assign accept    = req_valid && req_ready;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_rsp_ff;

   // Switchable bank modulo bank count; bank is at most 7, so three
   // conditional subtractions are enough for any count from 2 to 16
   always_comb begin
      bank_mod = {1'b0, bank_ff};
      for (int k = 0; k < 3; k++) begin
         if (bank_mod >= BANKS_N) begin
            bank_mod = bank_mod - BANKS_N;
         end
      end
      wram_bank = dec_ctl.wram_banked ? bank_mod[BANK_W-1:0] : '0;
   end

   // RAM port muxing: clearing pass owns the ports until it finishes
   always_comb begin
      hram_clr   = clr_active_ff && (clr_cnt_ff < WRAM_AW'(hcbd_pkg::HRAM_BYTES));
      wram_en    = clr_active_ff || (accept && dec_ctl.wram_en);
      wram_we    = clr_active_ff || (accept && dec_ctl.wram_we);
      wram_addr  = clr_active_ff ? clr_cnt_ff
                 : {wram_bank, req_payload.address[hcbd_pkg::BANK_OFS_W-1:0]};
      wram_wdata = clr_active_ff ? 8'h00 : req_payload.write_data;
      hram_en    = hram_clr || (accept && dec_ctl.hram_en);
      hram_we    = hram_clr || (accept && dec_ctl.hram_we);
      hram_addr  = clr_active_ff ? clr_cnt_ff[hcbd_pkg::HRAM_AW-1:0]
                 : req_payload.address[hcbd_pkg::HRAM_AW-1:0];
      hram_wdata = clr_active_ff ? 8'h00 : req_payload.write_data;
   end

   hcbd_ram #(
      .DEPTH (WRAM_DEPTH),
      .WIDTH (8)
   ) u_wram (
      .clock (clock),
      .en    (wram_en),
      .we    (wram_we),
      .addr  (wram_addr),
      .wdata (wram_wdata),
      .rdata (wram_rdata)
   );

   hcbd_ram #(
      .DEPTH (hcbd_pkg::HRAM_BYTES),
      .WIDTH (8)
   ) u_hram (
      .clock (clock),
      .en    (hram_en),
      .we    (hram_we),
      .addr  (hram_addr),
      .wdata (hram_wdata),
      .rdata (hram_rdata)
   );

   // Next state of local registers and clearing pass
   always_comb begin
      cart_in  = csr_write_enable ? csr_write_data : cart_ff;
      boot_in  = boot_ff;
      bank_in  = bank_ff;
      mode_in  = mode_ff;
      speed_in = speed_ff;
      if (accept) begin
         if (dec_ctl.boot_clr) boot_in = 1'b0;
         if (dec_ctl.mode_we)  mode_in = req_payload.write_data;
         if (dec_ctl.speed_we) speed_in = {speed_ff[7:1], req_payload.write_data[0]};
         if (dec_ctl.bank_we) begin
            // writing zero selects bank 1
            bank_in = (req_payload.write_data[2:0] == 3'd0) ? hcbd_pkg::BANK_DFLT
                    : req_payload.write_data[2:0];
         end
      end

      clr_active_in = clr_active_ff;
      clr_cnt_in    = clr_cnt_ff;
      if (clr_active_ff) begin
         if (clr_cnt_ff == WRAM_AW'(WRAM_DEPTH - 1)) begin
            clr_active_in = 1'b0;
         end else begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
      end
   end

   // Pipeline next state
   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_move);
      s1_rsp_in    = accept ? dec_rsp : s1_rsp_ff;
      s1_src_in    = accept ? dec_ctl.src : s1_src_ff;
      out_valid_in = s1_move || (out_valid_ff && !rsp_ready);
      out_rsp_in   = out_rsp_ff;
      if (s1_move) begin
         out_rsp_in = s1_rsp_ff;
         unique case (s1_src_ff)
            hcbd_pkg::SRC_WRAM: out_rsp_in.read_data = wram_rdata;
            hcbd_pkg::SRC_HRAM: out_rsp_in.read_data = hram_rdata;
            default:            out_rsp_in.read_data = s1_rsp_ff.read_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cart_ff       <= 1'b1;
         boot_ff       <= 1'b1;
         bank_ff       <= hcbd_pkg::BANK_DFLT;
         mode_ff       <= 8'h00;
         speed_ff      <= 8'h00;
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cart_ff       <= cart_in;
         boot_ff       <= boot_in;
         bank_ff       <= bank_in;
         mode_ff       <= mode_in;
         speed_ff      <= speed_in;
         clr_active_ff <= clr_active_in;
         clr_cnt_ff    <= clr_cnt_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      s1_rsp_ff  <= s1_rsp_in;
      s1_src_ff  <= s1_src_in;
      out_rsp_ff <= out_rsp_in;
   end

endmodule

// ----- hw/rtl/hcbd_checker.sv -----
// Port-level checker for the bus decoder, bound to the top level.
// Depends on hcbd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hcbd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input hcbd_pkg::rsp_type rsp_payload
);

   // stalled result holds
   property p_rsp_hold;
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload);
   endproperty

   // clearing pass blocks input and no result is pending after reset
   property p_reset_quiet;
      reset |=> !req_ready && !rsp_valid;
   endproperty

   // a forwarded write is never also a local read answer
   property p_fwd_vs_local;
      rsp_valid && rsp_payload.target_write |->
         !rsp_payload.read_valid && rsp_payload.target != hcbd_pkg::TGT_NONE;
   endproperty

   // unused data fields are zero
   property p_zero_fields;
      rsp_valid |-> (rsp_payload.read_valid || rsp_payload.read_data == 8'h00) &&
                    (rsp_payload.target_write || rsp_payload.forward_data == 8'h00);
   endproperty

   `HCBD_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold, "stalled rsp item changed")
   `HCBD_ASSERT_ALWAYS(a_reset_quiet, clock, p_reset_quiet, "block not quiet after reset")
   `HCBD_ASSERT(a_fwd_vs_local, clock, reset, p_fwd_vs_local, "forwarded write inconsistent")
   `HCBD_ASSERT(a_zero_fields, clock, reset, p_zero_fields, "unused data field not zero")

endmodule

bind handheld_console_bus_decoder_top hcbd_checker u_hcbd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ----- tb/sv/handheld_console_bus_decoder_top_tb.sv -----
// Self-checking testbench for handheld_console_bus_decoder_top: directed table, then random
// accesses checked against an in-bench memory-map predictor. Depends on hcbd_pkg and the top.
// Needs nothing else; stops on its own after the last result or at the time limit.
module handheld_console_bus_decoder_top_tb;

   localparam int N_BANKS   = 8;
   localparam int DRAIN_GAP = 4;       // output path is two registers deep
   localparam int LONG_HOLD = 150;     // cycles the sink refuses results in one go

   // Boot ROM overlay leaves a hole for the cartridge header
   localparam logic [15:0] BOOT_GAP_LO = 16'h0100;
   localparam logic [15:0] BOOT_GAP_HI = 16'h01FF;

   // I/O offsets in page FF not named by the package
   localparam logic [7:0] IO_SB       = 8'h01;
   localparam logic [7:0] IO_DIV      = 8'h04;
   localparam logic [7:0] IO_TAC      = 8'h07;
   localparam logic [7:0] IO_NR10     = 8'h10;
   localparam logic [7:0] IO_APU_END  = 8'h27;
   localparam logic [7:0] IO_WAVE_END = 8'h3F;
   localparam logic [7:0] IO_LCDC     = 8'h40;
   localparam logic [7:0] IO_WX       = 8'h4B;
   localparam logic [7:0] IO_HDMA1    = 8'h51;
   localparam logic [7:0] IO_HDMA4    = 8'h54;
   localparam logic [7:0] IO_BCPS     = 8'h68;
   localparam logic [7:0] IO_OCPD     = 8'h6B;
   localparam logic [7:0] IO_LAST     = 8'h7F;

   // Register offsets the random part leans on: every boundary of every I/O range
   localparam logic [7:0] IO_PICKS [25] = '{
      hcbd_pkg::IO_PAD, IO_SB, IO_DIV, IO_TAC, hcbd_pkg::IO_IF, IO_NR10, IO_APU_END,
      hcbd_pkg::WAVE_BASE, IO_WAVE_END, IO_LCDC, hcbd_pkg::IO_LY, hcbd_pkg::IO_OAMDMA,
      IO_WX, hcbd_pkg::IO_KEY0, hcbd_pkg::IO_KEY1, hcbd_pkg::IO_VBK, hcbd_pkg::IO_BOOT,
      IO_HDMA1, IO_HDMA4, hcbd_pkg::IO_HDMA5, IO_BCPS, IO_OCPD, hcbd_pkg::IO_OPRI,
      hcbd_pkg::IO_SVBK, IO_LAST};

   localparam hcbd_pkg::rsp_type QUIET_RSP = '0;

   typedef enum logic {ROW_ACCESS, ROW_CART} row_kind_type;

   typedef struct {
      row_kind_type      kind;    // ROW_CART rows carry the new cartridge flag in write_data[0]
      bit                typed;   // want holds a hand-written result
      hcbd_pkg::req_type acc;
      hcbd_pkg::rsp_type want;
   } row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   hcbd_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   hcbd_pkg::rsp_type rsp_payload;
   logic              csr_write_enable;
   logic              csr_write_data;

   // Predictor copy of the block's state
   logic [7:0] wram_copy [N_BANKS * hcbd_pkg::WRAM_BANK_BYTES];
   logic [7:0] hram_copy [hcbd_pkg::HRAM_BYTES];
   logic [2:0] wram_bank;
   logic       boot_on;
   logic [7:0] mode_key;
   logic [7:0] speed_key;
   logic       cart_on;

   hcbd_pkg::rsp_type due_rsps [$];   // results owed by the block, oldest first
   row_type           plan [$];       // directed table
   bit                row_typed;      // travels with the item on req_payload
   hcbd_pkg::rsp_type row_want;
   int unsigned       accepted;
   int unsigned       reads_seen;
   int unsigned       writes_seen;
   int unsigned       results_seen;
   int unsigned       mismatch_count;
   int unsigned       cart_settings;
   int unsigned       long_holds;
   bit                steady_source;
   bit                steady_sink;
   bit                hold_asked;
   hcbd_pkg::rsp_type oldest;

   handheld_console_bus_decoder_top #(
      .WRAM_BANKS (N_BANKS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop, well beyond the clearing pass and a slow correct run.
   initial begin
      #2000000;
      $display("handheld_console_bus_decoder_top_tb NOT OK");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Predictor: decodes one access against the memory map and applies its side
   // effects to the copy of the state above. Called once per accepted item, in
   // order of acceptance.
   // ---------------------------------------------------------------------------
   function automatic hcbd_pkg::rsp_type decode_access(hcbd_pkg::req_type acc);
      hcbd_pkg::rsp_type res;
      logic              wr;
      logic [15:0]       a;
      logic [7:0]        io;
      logic [7:0]        d;
      logic [3:0]        tgt;
      logic [14:0]       ofs;
      logic              own;
      logic [7:0]        rd;
      logic [14:0]       wix;
      logic [6:0]        hix;
      wr  = (acc.operation == hcbd_pkg::OP_WRITE);
      a   = acc.address;
      io  = a[7:0];
      d   = acc.write_data;
      tgt = hcbd_pkg::TGT_NONE;
      ofs = '0;
      own = 1'b0;
      rd  = hcbd_pkg::OPEN_BUS;
      if (!a[15]) begin
         // ROM space: boot overlay first, then cartridge, else open bus
         if (boot_on && (a < BOOT_GAP_LO || a > BOOT_GAP_HI)) begin
            if (!wr) begin
               tgt = hcbd_pkg::TGT_BOOT;
               ofs = a[14:0];
            end
         end else if (cart_on) begin
            tgt = hcbd_pkg::TGT_CROM;
            ofs = a[14:0];
         end else begin
            own = 1'b1;
         end
      end else if (a[15:13] == 3'b100) begin
         tgt = hcbd_pkg::TGT_VRAM;
         ofs = {2'b00, a[12:0]};
      end else if (a[15:13] == 3'b101) begin
         if (cart_on) begin
            tgt = hcbd_pkg::TGT_CRAM;
            ofs = {2'b00, a[12:0]};
         end else begin
            own = 1'b1;
         end
      end else if (a[15:8] <= 8'hFD) begin
         // C000 and its echo E000 are bank 0; D000 and F000 follow the bank register
         wix = 15'((a[12] ? int'(wram_bank) % N_BANKS : 0) * hcbd_pkg::WRAM_BANK_BYTES
                   + int'(a[11:0]));
         own = 1'b1;
         if (wr) wram_copy[wix] = d;
         else rd = wram_copy[wix];
      end else if (a[15:8] == 8'hFE) begin
         tgt = hcbd_pkg::TGT_OAM;
         ofs = {7'd0, io};
      end else if (a == 16'hFFFF) begin
         tgt = hcbd_pkg::TGT_IE;
         ofs = {7'd0, io};
      end else if (a[7]) begin
         hix = a[6:0];
         own = 1'b1;
         if (wr) hram_copy[hix] = d;
         else rd = hram_copy[hix];
      end else begin
         own = 1'b1;
         if (io == hcbd_pkg::IO_PAD) tgt = hcbd_pkg::TGT_PAD;
         else if (io >= IO_DIV && io <= IO_TAC) tgt = hcbd_pkg::TGT_TIMER;
         else if (io == hcbd_pkg::IO_IF) tgt = hcbd_pkg::TGT_IF;
         else if (io >= IO_NR10 && io <= IO_APU_END) tgt = hcbd_pkg::TGT_APU;
         else if (io >= hcbd_pkg::WAVE_BASE && io <= IO_WAVE_END) tgt = hcbd_pkg::TGT_WAVE;
         else if ((io >= IO_LCDC && io <= IO_WX && io != hcbd_pkg::IO_LY &&
                   io != hcbd_pkg::IO_OAMDMA) ||
                  io == hcbd_pkg::IO_VBK || (io >= IO_BCPS && io <= IO_OCPD))
            tgt = hcbd_pkg::TGT_PPU;
         else if (io == hcbd_pkg::IO_LY) begin
            if (!wr) tgt = hcbd_pkg::TGT_PPU;
         end else if (io == hcbd_pkg::IO_OAMDMA) begin
            if (wr) tgt = hcbd_pkg::TGT_PPU;
         end else if (io == hcbd_pkg::IO_OPRI) begin
            if (!wr || boot_on) tgt = hcbd_pkg::TGT_PPU;
         end else if (io >= IO_HDMA1 && io <= IO_HDMA4) begin
            if (wr) tgt = hcbd_pkg::TGT_DMA;
         end else if (io == hcbd_pkg::IO_HDMA5) begin
            tgt = hcbd_pkg::TGT_DMA;
         end else if (io == hcbd_pkg::IO_KEY0) begin
            if (wr) begin
               if (boot_on) mode_key = d;
            end else begin
               rd = mode_key;
            end
         end else if (io == hcbd_pkg::IO_KEY1) begin
            if (wr) speed_key[0] = d[0];
            else rd = mode_key[2] ? hcbd_pkg::OPEN_BUS : speed_key;
         end else if (io == hcbd_pkg::IO_BOOT) begin
            if (wr) boot_on = 1'b0;
            else rd = {7'd0, boot_on};
         end else if (io == hcbd_pkg::IO_SVBK) begin
            if (wr) wram_bank = (d[2:0] == 3'd0) ? hcbd_pkg::BANK_DFLT : d[2:0];
            else rd = {5'd0, wram_bank};
         end
         if (tgt != hcbd_pkg::TGT_NONE) begin
            own = 1'b0;
            ofs = (tgt == hcbd_pkg::TGT_WAVE) ? {7'd0, io - hcbd_pkg::WAVE_BASE}
                                              : {7'd0, io};
         end
      end
      res.target         = tgt;
      res.target_address = ofs;
      res.target_write   = wr && (tgt != hcbd_pkg::TGT_NONE);
      res.forward_data   = res.target_write ? d : 8'h00;
      res.read_valid     = !wr && own && (tgt == hcbd_pkg::TGT_NONE);
      res.read_data      = res.read_valid ? rd : 8'h00;
      return res;
   endfunction

   function automatic hcbd_pkg::rsp_type answer(logic [3:0] tgt, logic [14:0] ofs,
                                                logic fwd, logic [7:0] fdata, logic rv,
                                                logic [7:0] rd);
      return '{tgt, ofs, fwd, fdata, rv, rd};
   endfunction

   // Random access, weighted toward the regions with behavior behind them.
   // Work RAM and high RAM offsets cluster so reads land on earlier writes.
   function automatic hcbd_pkg::req_type random_access(bit may_clear);
      hcbd_pkg::req_type acc;
      int unsigned       pick;
      logic [11:0]       near;
      logic [6:0]        hofs;
      acc.operation  = 1'($urandom_range(0, 1));
      acc.write_data = 8'($urandom);
      case ($urandom_range(0, 2))
         0: near = 12'($urandom_range(0, 15));
         1: near = 12'($urandom_range(4080, 4095));
         default: near = 12'($urandom);
      endcase
      hofs = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 7)) : 7'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 8) acc.address = {1'b0, 15'($urandom)};
      else if (pick < 14) acc.address = {8'h01, 8'($urandom)};
      else if (pick < 20) acc.address = {3'b100, 13'($urandom)};
      else if (pick < 27) acc.address = {3'b101, 13'($urandom)};
      else if (pick < 45) acc.address = {3'b110, 1'($urandom_range(0, 1)), near};
      else if (pick < 55) acc.address = {3'b111, 1'($urandom_range(0, 1)), near};
      else if (pick < 60) acc.address = {8'hFE, 8'($urandom)};
      else if (pick < 70) acc.address = {9'h1FF, hofs};
      else if (pick < 85) acc.address = {8'hFF, IO_PICKS[5'($urandom_range(0, 24))]};
      else if (pick < 93) acc.address = {9'h1FE, 7'($urandom)};
      else acc.address = 16'($urandom);
      // echo ends at FDFF
      if (pick >= 45 && pick < 55 && acc.address[15:9] == 7'h7F) acc.address[9] = 1'b0;
      // the overlay is one-shot, so keep it up while its phases run
      if (!may_clear && acc.operation == hcbd_pkg::OP_WRITE &&
          acc.address == {8'hFF, hcbd_pkg::IO_BOOT})
         acc.operation = hcbd_pkg::OP_READ;
      return acc;
   endfunction

   task automatic add_row(row_kind_type kind, logic op, logic [15:0] a, logic [7:0] d,
                          bit typed, hcbd_pkg::rsp_type want);
      plan.push_back('{kind, typed, '{op, a, d}, want});
   endtask

   // Called at a falling edge; returns at the falling edge after the item is taken.
   // valid stays high into the next call unless that call idles first.
   task automatic offer(hcbd_pkg::req_type acc, bit typed, hcbd_pkg::rsp_type want);
      int unsigned base;
      if (!steady_source && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      base = accepted;
      req_valid   <= 1'b1;
      req_payload <= acc;
      row_typed   <= typed;
      row_want    <= want;
      do @(negedge clock); while (accepted == base);
   endtask

   // Stop offering and let every owed result come home
   task automatic drain_all();
      req_valid <= 1'b0;
      while (due_rsps.size() != 0) @(negedge clock);
      repeat (DRAIN_GAP) @(negedge clock);
   endtask

   task automatic set_cartridge(logic present);
      csr_write_enable <= 1'b1;
      csr_write_data   <= present;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cart_on = present;
      cart_settings++;
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Monitor. Results are retired before the new item is predicted; the output
   // path is registered, so an item's result never retires on its accept edge.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (due_rsps.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with nothing owed, expected none, actual %h",
                        $time, rsp_payload);
            end else begin
               oldest = due_rsps.pop_front();
               check_field("target", 32'(oldest.target), 32'(rsp_payload.target));
               check_field("target_address", 32'(oldest.target_address),
                           32'(rsp_payload.target_address));
               check_field("target_write", 32'(oldest.target_write),
                           32'(rsp_payload.target_write));
               check_field("forward_data", 32'(oldest.forward_data),
                           32'(rsp_payload.forward_data));
               check_field("read_valid", 32'(oldest.read_valid),
                           32'(rsp_payload.read_valid));
               check_field("read_data", 32'(oldest.read_data), 32'(rsp_payload.read_data));
               results_seen++;
            end
         end
         if (req_valid && req_ready) begin
            // Predict always so the state copy moves; hand-typed rows override
            oldest = decode_access(req_payload);
            due_rsps.push_back(row_typed ? row_want : oldest);
            accepted++;
            if (req_payload.operation == hcbd_pkg::OP_WRITE) writes_seen++;
            else reads_seen++;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result sink. About 15% refusals at random, none while steady_sink is set,
   // and a long refusal counted here whenever the stimulus asks for one: the
   // sender keeps offering meanwhile, so the block fills and drops req_ready.
   // ---------------------------------------------------------------------------
   initial begin : sink
      int unsigned hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_asked) begin
            hold_asked = 1'b0;
            hold_left  = LONG_HOLD - 1;
            long_holds++;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady_sink || ($urandom_range(0, 99) >= 15);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      row_type           r;
      hcbd_pkg::req_type acc;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      row_typed        = 1'b0;
      row_want         = QUIET_RSP;
      steady_source    = 1'b0;
      steady_sink      = 1'b0;
      hold_asked       = 1'b0;
      accepted         = 0;
      reads_seen       = 0;
      writes_seen      = 0;
      results_seen     = 0;
      mismatch_count   = 0;
      cart_settings    = 0;
      long_holds       = 0;

      // state after reset
      foreach (wram_copy[i]) wram_copy[i] = 8'h00;
      foreach (hram_copy[i]) hram_copy[i] = 8'h00;
      wram_bank = hcbd_pkg::BANK_DFLT;
      boot_on   = 1'b1;
      mode_key  = 8'h00;
      speed_key = 8'h00;
      cart_on   = 1'b1;

      // Directed table. Overlay is on throughout; cartridge pulled for the tail.
      add_row(ROW_ACCESS, hcbd_pkg::OP_READ,  16'hFF50, 8'h00, 1,
              answer(hcbd_pkg::TGT_NONE, 0, 0, 0, 1, 8'h01));
      add_row(ROW_ACCESS, hcbd_pkg::OP_READ,  16'h0000, 8'h00, 1,
              answer(hcbd_pkg::TGT_BOOT, 0, 0, 0, 0, 0));
      add_row(ROW_ACCESS, hcbd_pkg::OP_READ,  16'h7FFF, 8'h00, 1,
              answer(hcbd_pkg::TGT_BOOT, 15'h7FFF, 0, 0, 0, 0));
      // header hole in the overlay reaches the cartridge
      add_row(ROW_ACCESS, hcbd_pkg::OP_READ,  16'h0100, 8'h00, 1,
              answer(hcbd_pkg::TGT_CROM, 15'h0100, 0, 0, 0, 0));
      // write under the overlay is swallowed
      add_row(ROW_ACCESS, hcbd_pkg::OP_WRITE, 16'h0000, 8'hA5, 1, QUIET_RSP);
      add_row(ROW_ACCESS, hcbd_pkg::OP_WRITE, 16'h01FF, 8'h5A, 1,
              answer(hcbd_pkg::TGT_CROM, 15'h01FF, 1, 8'h5A, 0, 0));
      add_row(ROW_ACCESS, hcbd_pkg::OP_READ,  16'hBFFF, 8'h00, 1,
              answer(hcbd_pkg::TGT_CRAM, 15'h1FFF, 0, 0, 0, 0));
      add_row(ROW_ACCESS, hcbd_pkg::OP_WRITE, 16'hFE9F, 8'h33, 1,
              answer(hcbd_pkg::TGT_OAM, 15'h009F, 1, 8'h33, 0, 0));
      add_row(ROW_ACCESS, hcbd_pkg::OP_WRITE, 16'hFF3F, 8'hC3, 1,
              answer(hcbd_pkg::TGT_WAVE, 15'h000F, 1, 8'hC3, 0, 0));
      // compatibility mode on: speed key reads open bus
      add_row(ROW_ACCESS, hcbd_pkg::OP_WRITE, 16'hFF4C, 8'h04, 1, QUIET_RSP);
      add_row(ROW_ACCESS, hcbd_pkg::OP_READ,  16'hFF4D, 8'h00, 1,
              answer(hcbd_pkg::TGT_NONE, 0, 0, 0, 1, 8'hFF));
      add_row(ROW_ACCESS, hcbd_pkg::OP_WRITE, 16'hFF4C, 8'h00, 0, QUIET_RSP);
      add_row(ROW_ACCESS, hcbd_pkg::OP_WRITE, 16'hFF4D, 8'hFF, 0, QUIET_RSP);
      add_row(ROW_ACCESS, hcbd_pkg::OP_READ,  16'hFF4D, 8'h00, 1,
              answer(hcbd_pkg::TGT_NONE, 0, 0, 0, 1, 8'h01));
      add_row(ROW_ACCESS, hcbd_pkg::OP_WRITE, 16'hFF6C, 8'h5A, 1,
              answer(hcbd_pkg::TGT_PPU, 15'h006C, 1, 8'h5A, 0, 0));
      add_row(ROW_ACCESS, hcbd_pkg::OP_WRITE, 16'hFF44, 8'h11, 1, QUIET_RSP);
      add_row(ROW_ACCESS, hcbd_pkg::OP_READ,  16'hFF46, 8'h00, 1,
              answer(hcbd_pkg::TGT_NONE, 0, 0, 0, 1, 8'hFF));
      // bank 0 written to the bank register selects bank 1
      add_row(ROW_ACCESS, hcbd_pkg::OP_WRITE, 16'hFF70, 8'h00, 0, QUIET_RSP);
      add_row(ROW_ACCESS, hcbd_pkg::OP_READ,  16'hFF70, 8'h00, 1,
              answer(hcbd_pkg::TGT_NONE, 0, 0, 0, 1, 8'h01));
      add_row(ROW_ACCESS, hcbd_pkg::OP_WRITE, 16'hFF70, 8'hFF, 0, QUIET_RSP);
      // upper echo mirrors the switched bank
      add_row(ROW_ACCESS, hcbd_pkg::OP_WRITE, 16'hDDFF, 8'h3C, 0, QUIET_RSP);
      add_row(ROW_ACCESS, hcbd_pkg::OP_READ,  16'hFDFF, 8'h00, 0, QUIET_RSP);
      add_row(ROW_ACCESS, hcbd_pkg::OP_READ,  16'hFFFE, 8'h00, 1,
              answer(hcbd_pkg::TGT_NONE, 0, 0, 0, 1, 8'h00));
      add_row(ROW_ACCESS, hcbd_pkg::OP_WRITE, 16'hFFFF, 8'h00, 1,
              answer(hcbd_pkg::TGT_IE, 15'h00FF, 1, 8'h00, 0, 0));
      // no cartridge: ROM hole and cart RAM read open bus, writes vanish
      add_row(ROW_CART,   hcbd_pkg::OP_WRITE, 16'h0000, 8'h00, 0, QUIET_RSP);
      add_row(ROW_ACCESS, hcbd_pkg::OP_READ,  16'h0150, 8'h00, 1,
              answer(hcbd_pkg::TGT_NONE, 0, 0, 0, 1, 8'hFF));
      add_row(ROW_ACCESS, hcbd_pkg::OP_READ,  16'hA000, 8'h00, 1,
              answer(hcbd_pkg::TGT_NONE, 0, 0, 0, 1, 8'hFF));
      add_row(ROW_ACCESS, hcbd_pkg::OP_WRITE, 16'hBFFF, 8'h77, 1, QUIET_RSP);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // First register write lands during the RAM clearing pass, which the
      // block allows; req_ready holds the items off until the pass is done.
      set_cartridge(1'b1);

      foreach (plan[i]) begin
         r = plan[i];
         if (r.kind == ROW_CART) begin
            drain_all();
            set_cartridge(r.acc.write_data[0]);
         end else begin
            offer(r.acc, r.typed, r.want);
         end
      end

      // Random phases: cartridge flag, may the overlay be cleared, item count,
      // steady (no idling on either side, the long stretch without gaps).
      // Overlay-on phases come first since clearing it is one-shot.
      for (int ph = 0; ph < 5; ph++) begin
         int unsigned count;
         bit          cart;
         bit          may_clear;
         bit          steady;
         case (ph)
            0: begin cart = 1'b1; may_clear = 1'b0; count = 450; steady = 1'b0; end
            1: begin cart = 1'b0; may_clear = 1'b0; count = 200; steady = 1'b0; end
            2: begin cart = 1'b1; may_clear = 1'b1; count = 500; steady = 1'b1; end
            3: begin cart = 1'b0; may_clear = 1'b1; count = 250; steady = 1'b0; end
            default: begin cart = 1'b1; may_clear = 1'b1; count = 400; steady = 1'b0; end
         endcase
         drain_all();
         set_cartridge(cart);
         steady_source = steady;
         steady_sink   = steady;
         for (int unsigned k = 0; k < count; k++) begin
            // make sure the overlay really goes away early in the first phase allowed
            if (may_clear && boot_on && k == 60)
               acc = '{hcbd_pkg::OP_WRITE, {8'hFF, hcbd_pkg::IO_BOOT}, 8'($urandom)};
            else
               acc = random_access(may_clear);
            if (!steady && k == count / 3) hold_asked = 1'b1;
            offer(acc, 1'b0, QUIET_RSP);
         end
         steady_source = 1'b0;
         steady_sink   = 1'b0;
      end

      drain_all();

      $display("Covered %0d accesses (%0d reads, %0d writes) over %0d cartridge settings,",
               accepted, reads_seen, writes_seen, cart_settings);
      $display("boot overlay on then off, %0d long output stalls; %0d results compared.",
               long_holds, results_seen);
      if (mismatch_count == 0)
         $display("handheld_console_bus_decoder_top_tb OK");
      else
         $display("handheld_console_bus_decoder_top_tb NOT OK");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/hcbd_pkg.sv
hw/rtl/hcbd_ram.sv
hw/rtl/hcbd_decode.sv
hw/rtl/handheld_console_bus_decoder_top.sv
hw/rtl/hcbd_checker.sv
tb/sv/handheld_console_bus_decoder_top_tb.sv
